>>> sv/eul_pkg.sv
// Shared constants, types and helper functions for the Euler rotation matrix block.
package eul_pkg;
	localparam int TRIG_STAGES = 16;
	localparam int ENTRY_WIDTH = 16;
	localparam int FRAC_BITS = ENTRY_WIDTH - 2;
	localparam int VW = 34;
	localparam int ZW = 28;
	localparam int PW = 2 * ENTRY_WIDTH + 3;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic signed [VW-1:0] GAIN_INV = VW'(652032874);
	localparam logic signed [ENTRY_WIDTH-1:0] ONE_FIX = ENTRY_WIDTH'(1) <<< FRAC_BITS;

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [ZW-1:0] ang_t;
	typedef logic signed [ENTRY_WIDTH-1:0] ent_t;

	typedef struct packed {
		vec_t x;
		vec_t y;
		ang_t z;
	} cvec_t;

	typedef struct packed {
		cvec_t ax;
		cvec_t ay;
		cvec_t az;
		logic [2:0] flip;
	} trio_t;

	function automatic ang_t atan_q24(input int i);
		case (i)
			0: atan_q24 = ZW'(13176795);
			1: atan_q24 = ZW'(7778716);
			2: atan_q24 = ZW'(4110060);
			3: atan_q24 = ZW'(2086331);
			4: atan_q24 = ZW'(1047214);
			5: atan_q24 = ZW'(524117);
			6: atan_q24 = ZW'(262123);
			7: atan_q24 = ZW'(131069);
			default: atan_q24 = (i < 24) ? ZW'(64'sd1 <<< (24 - i)) : '0;
		endcase
	endfunction

	function automatic ent_t sat_v(input logic signed [PW-1:0] v);
		if (v > PW'(ONE_FIX)) sat_v = ONE_FIX;
		else if (v < -PW'(ONE_FIX)) sat_v = -ONE_FIX;
		else sat_v = ENTRY_WIDTH'(v);
	endfunction

	function automatic ent_t round_vec(input vec_t v, input logic neg);
		logic signed [VW:0] t;
		logic signed [VW:0] r;
		t = neg ? -{v[VW-1], v} : {v[VW-1], v};
		r = (t + ((VW+1)'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		round_vec = sat_v(PW'(r));
	endfunction

	function automatic ent_t round_acc(input logic signed [PW-1:0] a);
		round_acc = sat_v((a + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
	endfunction
endpackage

>>> sv/eul_cell.sv
// One CORDIC rotation cell for three angles, registered, with its own valid bit.
module eul_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [4:0] stage,
	input  logic v_in,
	input  eul_pkg::trio_t d_in,
	output logic v_out,
	output eul_pkg::trio_t d_out
);
	import eul_pkg::*;

	function automatic cvec_t rot(input cvec_t c, input logic [4:0] s);
		cvec_t r;
		if (c.z >= 0) begin
			r.x = c.x - (c.y >>> s);
			r.y = c.y + (c.x >>> s);
			r.z = c.z - atan_q24(int'(s));
		end else begin
			r.x = c.x + (c.y >>> s);
			r.y = c.y - (c.x >>> s);
			r.z = c.z + atan_q24(int'(s));
		end
		return r;
	endfunction

	trio_t nxt;
	always_comb begin
		nxt.ax = rot(d_in.ax, stage);
		nxt.ay = rot(d_in.ay, stage);
		nxt.az = rot(d_in.az, stage);
		nxt.flip = d_in.flip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out <= 1'b0;
		else if (en) v_out <= v_in;
	end
	always_ff @(posedge clk) begin
		if (en) d_out <= nxt;
	end
endmodule

>>> sv/euler_xyz_rotation_matrix.sv
// Top level: CORDIC cell chain, sine/cosine rounding and two matrix product stages.
//  channel | valid    | ready    | payload
//  input   | in_valid | in_ready | angle_x angle_y angle_z
//  output  | out_valid| out_ready| r00 .. r22
// One transaction per cycle unless stalled; data passes through the cell chain, then
// the sine/cosine, product and output registers. The whole pipeline advances when the output register is
// empty or taken, so a stall holds every stage. Reset clears only the valid bits.
module euler_xyz_rotation_matrix (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	output logic out_valid,
	input  logic out_ready,
	output eul_pkg::ent_t r00, output eul_pkg::ent_t r01, output eul_pkg::ent_t r02,
	output eul_pkg::ent_t r10, output eul_pkg::ent_t r11, output eul_pkg::ent_t r12,
	output eul_pkg::ent_t r20, output eul_pkg::ent_t r21, output eul_pkg::ent_t r22
);
	import eul_pkg::*;

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	function automatic cvec_t init(input logic signed [15:0] a, output logic f);
		cvec_t c;
		logic signed [15:0] b;
		f = 1'b0;
		b = a;
		if (a > HALF_PI_Q13) begin
			b = a - PI_Q13; f = 1'b1;
		end else if (a < -HALF_PI_Q13) begin
			b = a + PI_Q13; f = 1'b1;
		end
		c.x = GAIN_INV;
		c.y = '0;
		c.z = ZW'(b) <<< 11;
		return c;
	endfunction

	trio_t d0;
	always_comb begin
		d0.ax = init(angle_x, d0.flip[0]);
		d0.ay = init(angle_y, d0.flip[1]);
		d0.az = init(angle_z, d0.flip[2]);
	end

	trio_t chain_d [TRIG_STAGES+1];
	logic chain_v [TRIG_STAGES+1];
	assign chain_d[0] = d0;
	assign chain_v[0] = in_valid;

	for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
		eul_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .stage(5'(g)),
			.v_in(chain_v[g]), .d_in(chain_d[g]),
			.v_out(chain_v[g+1]), .d_out(chain_d[g+1])
		);
	end

	trio_t dl;
	assign dl = chain_d[TRIG_STAGES];

	// Stage 1: sine and cosine.
	ent_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	logic v_s1;
	// Stage 2: products of RY*RZ; stage 3: rounded entries.
	logic signed [PW-1:0] p00_s2, p01_s2, p02_s2, p10_s2, p11_s2, p20_s2, p21_s2, p22_s2;
	ent_t sx_s2, cx_s2, sx_s3, cx_s3;
	ent_t m00_s3, m01_s3, m02_s3, m10_s3, m11_s3, m20_s3, m21_s3, m22_s3;
	logic v_s2, v_s3, v_s4;
	// Stage 4: products of RX*(RY*RZ).
	logic signed [PW-1:0] q10a_s4, q10b_s4, q11a_s4, q11b_s4, q12a_s4, q12b_s4;
	logic signed [PW-1:0] q20a_s4, q20b_s4, q21a_s4, q21b_s4, q22a_s4, q22b_s4;
	ent_t m00_s4, m01_s4, m02_s4;

	function automatic logic signed [PW-1:0] mul(input ent_t a, input ent_t b);
		logic signed [2*ENTRY_WIDTH-1:0] p;
		p = a * b;
		return PW'(p);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= chain_v[TRIG_STAGES]; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= round_vec(dl.ax.x, dl.flip[0]); sx_s1 <= round_vec(dl.ax.y, dl.flip[0]);
			cy_s1 <= round_vec(dl.ay.x, dl.flip[1]); sy_s1 <= round_vec(dl.ay.y, dl.flip[1]);
			cz_s1 <= round_vec(dl.az.x, dl.flip[2]); sz_s1 <= round_vec(dl.az.y, dl.flip[2]);

			p00_s2 <= mul(cy_s1, cz_s1);
			p01_s2 <= -mul(cy_s1, sz_s1);
			p02_s2 <= PW'(sy_s1) <<< FRAC_BITS;
			p10_s2 <= PW'(sz_s1) <<< FRAC_BITS;
			p11_s2 <= PW'(cz_s1) <<< FRAC_BITS;
			p20_s2 <= -mul(sy_s1, cz_s1);
			p21_s2 <= mul(sy_s1, sz_s1);
			p22_s2 <= PW'(cy_s1) <<< FRAC_BITS;
			sx_s2 <= sx_s1; cx_s2 <= cx_s1;

			m00_s3 <= round_acc(p00_s2); m01_s3 <= round_acc(p01_s2);
			m02_s3 <= round_acc(p02_s2); m10_s3 <= round_acc(p10_s2);
			m11_s3 <= round_acc(p11_s2); m20_s3 <= round_acc(p20_s2);
			m21_s3 <= round_acc(p21_s2); m22_s3 <= round_acc(p22_s2);
			sx_s3 <= sx_s2; cx_s3 <= cx_s2;

			m00_s4 <= m00_s3; m01_s4 <= m01_s3; m02_s4 <= m02_s3;
			q10a_s4 <= mul(cx_s3, m10_s3); q10b_s4 <= mul(sx_s3, m20_s3);
			q11a_s4 <= mul(cx_s3, m11_s3); q11b_s4 <= mul(sx_s3, m21_s3);
			q12a_s4 <= '0;                 q12b_s4 <= mul(sx_s3, m22_s3);
			q20a_s4 <= -mul(sx_s3, m10_s3); q20b_s4 <= mul(cx_s3, m20_s3);
			q21a_s4 <= -mul(sx_s3, m11_s3); q21b_s4 <= mul(cx_s3, m21_s3);
			q22a_s4 <= '0;                  q22b_s4 <= mul(cx_s3, m22_s3);

			r00 <= m00_s4; r01 <= m01_s4; r02 <= m02_s4;
			r10 <= round_acc(q10a_s4 + q10b_s4);
			r11 <= round_acc(q11a_s4 + q11b_s4);
			r12 <= round_acc(q12a_s4 + q12b_s4);
			r20 <= round_acc(q20a_s4 + q20b_s4);
			r21 <= round_acc(q21a_s4 + q21b_s4);
			r22 <= round_acc(q22a_s4 + q22b_s4);
		end
	end
endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the XYZ Euler-angle rotation matrix block.
module tb_top;
	import eul_pkg::*;

	typedef logic signed [15:0] angle_t;
	typedef struct packed {
		ent_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	} rot_t;
	typedef struct {
		angle_t ax, ay, az;
		logic known;
		rot_t want;
	} stim_row_t;

	localparam int ONE = 1 << FRAC_BITS;
	localparam int LATENCY = TRIG_STAGES + 5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	angle_t angle_x = '0, angle_y = '0, angle_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ent_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

	rot_t rotation_q[$];
	int mismatches = 0;
	logic stim_done = 1'b0;
	logic quiet = 1'b0;
	logic hold_rx = 1'b0;

	euler_xyz_rotation_matrix dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22)
	);

	always #5 clk = ~clk;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	function automatic void trig(angle_t a, output longint sn, output longint cs);
		longint x, y, z, nx, t;
		int ang;
		logic flip;
		longint tab[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069};
		ang = int'(a);
		flip = 1'b0;
		if (ang > 12868) begin
			ang -= 25736;
			flip = 1'b1;
		end else if (ang < -12868) begin
			ang += 25736;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		z = longint'(ang) * 2048;
		for (int i = 0; i < TRIG_STAGES; i++) begin
			if (i < 8) t = tab[i];
			else if (i < 24) t = longint'(1) << (24 - i);
			else t = 0;
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= t;
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += t;
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cs = clamp_unit(floor_shift(x + (longint'(1) << (29 - FRAC_BITS)), 30 - FRAC_BITS));
		sn = clamp_unit(floor_shift(y + (longint'(1) << (29 - FRAC_BITS)), 30 - FRAC_BITS));
	endfunction

	function automatic rot_t euler_product(angle_t ax, angle_t ay, angle_t az);
		longint sx, cx, sy, cy, sz, cz, acc;
		longint mx[3][3], my[3][3], mz[3][3], myz[3][3], res[3][3];
		rot_t r;
		trig(ax, sx, cx);
		trig(ay, sy, cy);
		trig(az, sz, cz);
		mx = '{'{ONE, 0, 0}, '{0, cx, sx}, '{0, -sx, cx}};
		my = '{'{cy, 0, sy}, '{0, ONE, 0}, '{-sy, 0, cy}};
		mz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, ONE}};
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += my[i][k] * mz[k][j];
				myz[i][j] = clamp_unit(floor_shift(acc + (1 << (FRAC_BITS - 1)), FRAC_BITS));
			end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += mx[i][k] * myz[k][j];
				res[i][j] = clamp_unit(floor_shift(acc + (1 << (FRAC_BITS - 1)), FRAC_BITS));
			end
		r.m00 = ent_t'(res[0][0]); r.m01 = ent_t'(res[0][1]); r.m02 = ent_t'(res[0][2]);
		r.m10 = ent_t'(res[1][0]); r.m11 = ent_t'(res[1][1]); r.m12 = ent_t'(res[1][2]);
		r.m20 = ent_t'(res[2][0]); r.m21 = ent_t'(res[2][1]); r.m22 = ent_t'(res[2][2]);
		return r;
	endfunction

	function automatic rot_t identity_rot();
		rot_t r;
		r = '0;
		r.m00 = ONE_FIX;
		r.m11 = ONE_FIX;
		r.m22 = ONE_FIX;
		return r;
	endfunction

	task automatic send_angles(angle_t ax, angle_t ay, angle_t az, rot_t want);
		while (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		rotation_q.push_back(want);
		in_valid <= 1'b1;
		angle_x <= ax;
		angle_y <= ay;
		angle_z <= az;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic angle_t pick_angle();
		case ($urandom_range(3))
			0: return angle_t'($urandom);
			1: return angle_t'($urandom_range(25736)) - 16'sd12868;
			2: return $urandom_range(1) ? 16'sd32767 - angle_t'($urandom_range(8))
				: -16'sd32768 + angle_t'($urandom_range(8));
			default: return $urandom_range(1) ? 16'sd12868 + angle_t'($urandom_range(2)) - 16'sd1
				: -16'sd12868 + angle_t'($urandom_range(2)) - 16'sd1;
		endcase
	endfunction

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		angle_t edges[12] = '{0, 1, -1, 12867, 12868, 12869, -12867, -12868, -12869,
			25736, 32767, -32768};
		angle_t a, b, c;
		foreach (edges[i]) begin
			row.ax = edges[i];
			row.ay = edges[(i + 4) % 12];
			row.az = edges[(i + 7) % 12];
			row.known = 1'b0;
			rows.push_back(row);
		end
		row.ax = 0; row.ay = 0; row.az = 0; row.known = 1'b1; row.want = identity_rot();
		rows.push_front(row);
		row.known = 1'b0;
		row.ax = 16'sh5555; row.ay = 16'shAAAA; row.az = 16'sh7FFF; rows.push_back(row);
		row.ax = 16'shAAAA; row.ay = 16'sh5555; row.az = 16'sh8000; rows.push_back(row);
		row.ax = 12868; row.ay = 12868; row.az = 12868; rows.push_back(row);
		row.ax = -32768; row.ay = -32768; row.az = -32768; rows.push_back(row);
		row.ax = 32767; row.ay = 32767; row.az = 32767; rows.push_back(row);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_angles(rows[i].ax, rows[i].ay, rows[i].az,
				rows[i].known ? rows[i].want : euler_product(rows[i].ax, rows[i].ay, rows[i].az));
		for (int n = 0; n < 1030; n++) begin
			quiet <= (n >= 300 && n < 450);
			hold_rx <= (n >= 600 && n < 602);
			a = pick_angle();
			b = pick_angle();
			c = pick_angle();
			send_angles(a, b, c, euler_product(a, b, c));
		end
		in_valid <= 1'b0;
		stim_done <= 1'b1;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_ready <= 1'b0;
				for (stall = 0; stall < 60; stall++) @(posedge clk);
			end
			out_ready <= quiet || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		rot_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			if (rotation_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected transaction: %p", got);
			end else begin
				want = rotation_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		while (rotation_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end
endmodule
